// ===== src/assert_macros.svh =====
// assertion macros used by the quaternion normalizer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational property sampled on every rising clock edge outside reset
`define QN_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// property that must hold in the cycle after the trigger
`define QN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/qnorm_pkg.sv =====
// types and constants for the quaternion normalizer
package qnorm_pkg;

  localparam int NUM_COMP  = 4;
  localparam int COMP_W    = 16;
  localparam int OUT_W     = 16;
  localparam int MAG_W     = COMP_W;
  localparam int SQ_W      = 2 * COMP_W - 1;
  localparam int PAIR_W    = SQ_W + 1;
  localparam int SUM_W     = SQ_W + 2;
  localparam int REM_W     = SUM_W + 1;
  // quotient a^2 * 2^30 / S never exceeds 2^30
  localparam int QUOT_W    = 31;
  localparam int ROOT_BITS = (QUOT_W + 1) / 2;
  localparam int RT_W      = QUOT_W + 1;
  localparam int NRM_W     = OUT_W - 1;
  localparam int FRONT_DLY = 4;
  localparam int PIPE_DLY  = QUOT_W + ROOT_BITS;

  localparam logic [NRM_W-1:0] UNIT_ONE = NRM_W'(16384);
  localparam logic signed [OUT_W-1:0] UNIT_POS = 16'sd16384;
  localparam logic signed [OUT_W-1:0] UNIT_NEG = -16'sd16384;

  typedef struct packed {
    logic signed [COMP_W-1:0] comp_r;
    logic signed [COMP_W-1:0] comp_i;
    logic signed [COMP_W-1:0] comp_j;
    logic signed [COMP_W-1:0] comp_k;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] unit_r;
    logic signed [OUT_W-1:0] unit_i;
    logic signed [OUT_W-1:0] unit_j;
    logic signed [OUT_W-1:0] unit_k;
    logic                    zero_norm;
  } out_item_t;

  typedef struct packed {
    logic                valid;
    logic                zero;
    logic [NUM_COMP-1:0] neg;
  } ctrl_t;

endpackage

// ===== src/quaternion_normalize.sv =====
// top level of the quaternion normalizer: front end, four lanes, output register
//
// Input channel: in_valid / in_stall carry one quaternion (four signed q4.12
// components) per request. Output channel: out_valid / out_stall carry the
// unit quaternion as four signed q1.14 values, rounded to nearest with halves
// away from zero, plus zero_norm when all four inputs were zero (the result
// is then all zeros).
// Pipeline: 4 front-end stages (magnitude, square, pair sum, total), 31
// divider stages (one quotient bit each), 16 square-root stages (one root
// bit each) and the output register. Throughput: one request per cycle
// while out_stall does not hold the pipeline.
// Reset clears every valid bit at once; the block accepts requests in the
// first cycle after reset. When out_stall is high with a result waiting, the
// whole pipeline holds and in_stall rises in the same cycle; nothing is lost
// or repeated, and flow resumes in the same cycle in which out_stall is low.
module quaternion_normalize (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  qnorm_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output qnorm_pkg::out_item_t out_item
);
  import qnorm_pkg::*;

  logic                en;
  ctrl_t               front_ctl;
  logic [SQ_W-1:0]     sq   [NUM_COMP];
  logic [SUM_W-1:0]    sum;
  logic [NRM_W-1:0]    nrm  [NUM_COMP];
  logic signed [OUT_W-1:0] unit [NUM_COMP];
  ctrl_t               tail;
  out_item_t           out_nxt;

  ctrl_t               ctl_r [PIPE_DLY];
  out_item_t           out_r;
  logic                out_valid_r;

  logic                unit_ok;
  logic                unit_clear;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  qnorm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_item  (in_item),
    .ctl_o    (front_ctl),
    .sq_o     (sq),
    .sum_o    (sum)
  );

  for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
    qnorm_lane u_lane (
      .clk   (clk),
      .en    (en),
      .sq_i  (sq[c]),
      .sum_i (sum),
      .nrm_o (nrm[c])
    );
  end

  // sign and zero flag ride alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_DLY; i++) begin
        ctl_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl_r[0] <= front_ctl;
      for (int i = 1; i < PIPE_DLY; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
      out_valid_r <= tail.valid;
    end
  end

  assign tail = ctl_r[PIPE_DLY-1];

  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      if (tail.zero) begin
        unit[c] = '0;
      end else if (tail.neg[c]) begin
        unit[c] = OUT_W'(0) - {1'b0, nrm[c]};
      end else begin
        unit[c] = {1'b0, nrm[c]};
      end
    end
    out_nxt.unit_r    = unit[0];
    out_nxt.unit_i    = unit[1];
    out_nxt.unit_j    = unit[2];
    out_nxt.unit_k    = unit[3];
    out_nxt.zero_norm = tail.zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    unit_ok = (out_r.unit_r <= UNIT_POS) && (out_r.unit_r >= UNIT_NEG) &&
              (out_r.unit_i <= UNIT_POS) && (out_r.unit_i >= UNIT_NEG) &&
              (out_r.unit_j <= UNIT_POS) && (out_r.unit_j >= UNIT_NEG) &&
              (out_r.unit_k <= UNIT_POS) && (out_r.unit_k >= UNIT_NEG);
    unit_clear = (out_r.unit_r == '0) && (out_r.unit_i == '0) &&
                 (out_r.unit_j == '0) && (out_r.unit_k == '0);
  end

`include "assert_macros.svh"

  `QN_ASSERT_ALWAYS(a_unit_range, !out_valid_r || unit_ok, "normalized component out of range")
  `QN_ASSERT_ALWAYS(a_zero_pass, !(out_valid_r && out_r.zero_norm) || unit_clear,
                    "zero norm with nonzero result")
  `QN_ASSERT_NEXT(a_tail_hold, !en, $stable(ctl_r[PIPE_DLY-1]) && $stable(out_r),
                  "pipeline moved while held")

endmodule

// ===== src/qnorm_front.sv =====
// front end: magnitudes, squares and the sum of squares over four stages
module qnorm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  qnorm_pkg::in_item_t         in_item,
  output qnorm_pkg::ctrl_t            ctl_o,
  output logic [qnorm_pkg::SQ_W-1:0]  sq_o [qnorm_pkg::NUM_COMP],
  output logic [qnorm_pkg::SUM_W-1:0] sum_o
);
  import qnorm_pkg::*;

  logic [COMP_W-1:0]   comp      [NUM_COMP];
  logic [MAG_W-1:0]    mag_nxt   [NUM_COMP];
  logic [2*MAG_W-1:0]  prod_nxt  [NUM_COMP];
  ctrl_t               ctl1_nxt;

  logic [MAG_W-1:0]    mag_r     [NUM_COMP];
  logic [SQ_W-1:0]     sq2_r     [NUM_COMP];
  logic [SQ_W-1:0]     sq3_r     [NUM_COMP];
  logic [SQ_W-1:0]     sq4_r     [NUM_COMP];
  logic [PAIR_W-1:0]   pair_r    [2];
  logic [SUM_W-1:0]    sum_r;
  ctrl_t               ctl1_r, ctl2_r, ctl3_r, ctl4_r;

  always_comb begin
    comp[0] = in_item.comp_r;
    comp[1] = in_item.comp_i;
    comp[2] = in_item.comp_j;
    comp[3] = in_item.comp_k;
    ctl1_nxt.valid = in_valid;
    ctl1_nxt.zero  = 1'b1;
    for (int c = 0; c < NUM_COMP; c++) begin
      ctl1_nxt.neg[c] = comp[c][COMP_W-1];
      // most negative value maps to 2^(w-1), still fits unsigned
      mag_nxt[c] = comp[c][COMP_W-1] ? MAG_W'(~comp[c] + 1'b1) : comp[c];
      if (comp[c] != '0) begin
        ctl1_nxt.zero = 1'b0;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      prod_nxt[c] = mag_r[c] * mag_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        mag_r[c] <= mag_nxt[c];
        sq2_r[c] <= prod_nxt[c][SQ_W-1:0];
        sq3_r[c] <= sq2_r[c];
        sq4_r[c] <= sq3_r[c];
      end
      pair_r[0] <= PAIR_W'(sq2_r[0]) + PAIR_W'(sq2_r[1]);
      pair_r[1] <= PAIR_W'(sq2_r[2]) + PAIR_W'(sq2_r[3]);
      sum_r     <= SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]);
    end
  end

  assign ctl_o = ctl4_r;
  assign sq_o  = sq4_r;
  assign sum_o = sum_r;

endmodule

// ===== src/qnorm_div.sv =====
// pipelined restoring divider: floor(a^2 * 2^30 / S), one quotient bit per stage
module qnorm_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [qnorm_pkg::SQ_W-1:0]   sq_i,
  input  logic [qnorm_pkg::SUM_W-1:0]  sum_i,
  output logic [qnorm_pkg::QUOT_W-1:0] quot_o
);
  import qnorm_pkg::*;

  logic [SUM_W-1:0]  rem_r   [QUOT_W-1];
  logic [SUM_W-1:0]  dvs_r   [QUOT_W-1];
  logic [QUOT_W-1:0] quo_r   [QUOT_W];
  logic [SUM_W-1:0]  rem_nxt [QUOT_W-1];
  logic [QUOT_W-1:0] quo_nxt [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic [REM_W-1:0]  cand;
    logic [REM_W-1:0]  diff;
    logic [SUM_W-1:0]  dvs;
    logic [QUOT_W-1:0] quo;
    logic              ge;

    if (k == 0) begin : g_first
      // a^2 <= S, so the top quotient bit is 0 or 1
      assign cand = REM_W'(sq_i);
      assign dvs  = sum_i;
      assign quo  = '0;
    end else begin : g_next
      assign cand = {rem_r[k-1], 1'b0};
      assign dvs  = dvs_r[k-1];
      assign quo  = quo_r[k-1];
    end

    assign diff       = cand - {1'b0, dvs};
    assign ge         = (cand >= {1'b0, dvs});
    assign quo_nxt[k] = {quo[QUOT_W-2:0], ge};

    if (k < QUOT_W - 1) begin : g_rem
      assign rem_nxt[k] = ge ? diff[SUM_W-1:0] : cand[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvs_r[0] <= sum_i;
      for (int k = 1; k < QUOT_W - 1; k++) begin
        dvs_r[k] <= dvs_r[k-1];
      end
      for (int k = 0; k < QUOT_W - 1; k++) begin
        rem_r[k] <= rem_nxt[k];
      end
      for (int k = 0; k < QUOT_W; k++) begin
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quot_o = quo_r[QUOT_W-1];

endmodule

// ===== src/qnorm_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module qnorm_isqrt (
  input  logic                            clk,
  input  logic                            en,
  input  logic [qnorm_pkg::QUOT_W-1:0]    quot_i,
  output logic [qnorm_pkg::ROOT_BITS-1:0] root_o
);
  import qnorm_pkg::*;

  logic [RT_W-1:0] rem_r   [ROOT_BITS-1];
  logic [RT_W-1:0] res_r   [ROOT_BITS];
  logic [RT_W-1:0] rem_nxt [ROOT_BITS-1];
  logic [RT_W-1:0] res_nxt [ROOT_BITS];

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_stage
    // trial bit walks down two places per stage
    localparam logic [RT_W-1:0] STEP_BIT = {{(RT_W-1){1'b0}}, 1'b1} << (QUOT_W - 1 - 2 * j);
    logic [RT_W-1:0] rem_prev;
    logic [RT_W-1:0] res_prev;
    logic [RT_W-1:0] trial;
    logic            ge;

    if (j == 0) begin : g_first
      assign rem_prev = RT_W'(quot_i);
      assign res_prev = '0;
    end else begin : g_next
      assign rem_prev = rem_r[j-1];
      assign res_prev = res_r[j-1];
    end

    assign trial      = res_prev + STEP_BIT;
    assign ge         = (rem_prev >= trial);
    assign res_nxt[j] = ge ? ((res_prev >> 1) + STEP_BIT) : (res_prev >> 1);

    if (j < ROOT_BITS - 1) begin : g_rem
      assign rem_nxt[j] = ge ? (rem_prev - trial) : rem_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < ROOT_BITS - 1; j++) begin
        rem_r[j] <= rem_nxt[j];
      end
      for (int j = 0; j < ROOT_BITS; j++) begin
        res_r[j] <= res_nxt[j];
      end
    end
  end

  assign root_o = res_r[ROOT_BITS-1][ROOT_BITS-1:0];

endmodule

// ===== src/qnorm_lane.sv =====
// one component lane: divide, square root and round to the nearest q1.14 magnitude
module qnorm_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qnorm_pkg::SQ_W-1:0]  sq_i,
  input  logic [qnorm_pkg::SUM_W-1:0] sum_i,
  output logic [qnorm_pkg::NRM_W-1:0] nrm_o
);
  import qnorm_pkg::*;

  logic [QUOT_W-1:0]    quot;
  logic [ROOT_BITS-1:0] root;
  logic [ROOT_BITS:0]   half_up;
  logic [ROOT_BITS-1:0] nrm;

  qnorm_div u_div (
    .clk    (clk),
    .en     (en),
    .sq_i   (sq_i),
    .sum_i  (sum_i),
    .quot_o (quot)
  );

  qnorm_isqrt u_isqrt (
    .clk    (clk),
    .en     (en),
    .quot_i (quot),
    .root_o (root)
  );

  // largest n with 2n-1 <= root: halves round away from zero
  assign half_up = {1'b0, root} + 1'b1;
  assign nrm     = half_up[ROOT_BITS:1];

  always_comb begin
    if (nrm > ROOT_BITS'(UNIT_ONE)) begin
      nrm_o = UNIT_ONE;
    end else begin
      nrm_o = nrm[NRM_W-1:0];
    end
  end

endmodule
